// ===== hw/rtl/slot_vector_mod_alu_assert.svh =====
// assertion macros for the slot vector modular alu
// included by modules that carry concurrent checks
`ifndef SLOT_VECTOR_MOD_ALU_ASSERT_SVH
`define SLOT_VECTOR_MOD_ALU_ASSERT_SVH
`ifndef SYNTH
`define SVMA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define SVMA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define SVMA_ASSERT(label, clk, rst, prop)
`define SVMA_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== hw/rtl/svma_pkg.sv =====
// shared types and codes for the slot vector modular alu
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package svma_pkg;
  localparam int FUNC_BITS = 3;
  localparam int IDX_BITS = 12;
  localparam int SHIFT_BITS = 16;
  localparam int DATA_BITS = 32;

  typedef enum logic [2:0] {
    FN_WRITE  = 3'd0,
    FN_ADD    = 3'd1,
    FN_SUB    = 3'd2,
    FN_MUL    = 3'd3,
    FN_NEG    = 3'd4,
    FN_READ   = 3'd5,
    FN_SWAP   = 3'd6,
    FN_ROTATE = 3'd7
  } func_t;

  // classified command handed from front to back
  typedef struct packed {
    func_t                  func;
    logic                   in_range;
    logic [IDX_BITS-1:0]    idx;
    logic [DATA_BITS-1:0]   operand;
    logic signed [SHIFT_BITS-1:0] shift;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_PREP,
    ST_RED,
    ST_FIX,
    ST_STORE,
    ST_SHRED,
    ST_COPY,
    ST_PERM,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/svma_front.sv =====
// front end: accepts items, classifies them, queues commands
// depends on svma_pkg
`timescale 1ns / 1ps
`default_nettype none
module svma_front #(
  parameter int SLOTS = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_valid,
  output logic                           s_ready,
  input  wire [svma_pkg::FUNC_BITS-1:0]  func,
  input  wire [svma_pkg::IDX_BITS-1:0]   slot_index,
  input  wire [svma_pkg::DATA_BITS-1:0]  operand_value,
  input  wire [svma_pkg::SHIFT_BITS-1:0] shift_amount,
  output logic                           q_valid,
  input  wire                            q_ready,
  output svma_pkg::cmd_t                 q_cmd
);
  import svma_pkg::*;

  // two-entry queue
  cmd_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  cmd_t       cin;
  logic       push, pop;

  always_comb begin
    cin.func     = func_t'(func);
    cin.in_range = ({20'd0, slot_index} < 32'(SLOTS));
    cin.idx      = slot_index;
    cin.operand  = operand_value;
    cin.shift    = shift_amount;
  end

  assign s_ready = (count != 2'd2);
  assign push    = s_valid && s_ready;
  assign q_valid = (count != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_cmd   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= cin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `include "slot_vector_mod_alu_assert.svh"
  `SVMA_ASSERT(a_no_overflow, clk, rst, (count == 2'd2) |-> !push)
  `SVMA_ASSERT(a_no_underflow, clk, rst, (count == 2'd0) |-> !pop)
  `SVMA_ASSERT(a_count_track, clk, rst, (push && !pop) |=> (count == $past(count) + 2'd1))
endmodule
`default_nettype wire

// ===== hw/rtl/svma_back.sv =====
// back end: slot memory, modular arithmetic, swaps and rotations, output register
// depends on svma_pkg
`timescale 1ns / 1ps
`default_nettype none
module svma_back #(
  parameter int SLOTS      = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire [svma_pkg::DATA_BITS-1:0] modulus,
  input  wire                           q_valid,
  output logic                          q_ready,
  input  svma_pkg::cmd_t                q_cmd,
  output logic                          m_valid,
  input  wire                           m_ready,
  output logic [svma_pkg::DATA_BITS-1:0] slot_result
);
  import svma_pkg::*;

  localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HALF = SLOTS / 2;
  localparam int HW   = (HALF > 1) ? $clog2(HALF) + 1 : 2;
  localparam int VB   = VALUE_BITS;
  localparam int CW   = AW + 1;

  state_t state, state_next;

  logic [VB-1:0]   store [SLOTS];
  logic [VB-1:0]   copy  [SLOTS];
  logic            vld   [SLOTS];

  cmd_t            cmd;
  logic [VB-1:0]   m_eff;
  logic [VB-1:0]   x, a;
  logic [2*VB-1:0] prod;
  logic [VB:0]     rem;
  logic [6:0]      bitc;
  logic [VB-1:0]   res;
  logic [CW-1:0]   cnt;
  logic [HW-1:0]   r_sh;
  logic [16:0]     shv;

  logic [VB-1:0]   mlo;
  logic [VB-1:0]   rd_val;
  logic [VB-1:0]   cp_val;
  logic [AW-1:0]   cidx, sidx;
  logic [HW-1:0]   jsum;

  assign mlo   = modulus[VB-1:0];
  assign cidx  = cnt[AW-1:0];
  assign rd_val = vld[cmd.idx[AW-1:0]] ? store[cmd.idx[AW-1:0]] : '0;

  // permutation source index for the current destination cnt
  always_comb begin
    logic [HW-1:0] col;
    logic          hi;
    col  = '0;
    hi   = 1'b0;
    jsum = '0;
    sidx = cidx;
    if (HALF >= 1) begin
      hi  = ({1'b0, cnt} >= (CW+1)'(HALF));
      col = hi ? HW'(cnt - CW'(HALF)) : HW'(cnt);
      jsum = col + r_sh;
      if (jsum >= HW'(HALF)) jsum = jsum - HW'(HALF);
      if (state == ST_PERM && cmd.func == FN_SWAP)
        sidx = hi ? AW'(col) : AW'(col + HW'(HALF));
      else
        sidx = hi ? AW'(jsum + HW'(HALF)) : AW'(jsum);
    end
  end
  assign cp_val = copy[sidx];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid && !m_valid) state_next = ST_LOAD;
      ST_LOAD: begin
        if (cmd.func == FN_SWAP)
          state_next = (SLOTS >= 2) ? ST_COPY : ST_DONE;
        else if (cmd.func == FN_ROTATE)
          state_next = (SLOTS >= 2) ? ST_SHRED : ST_DONE;
        else if (!cmd.in_range) state_next = ST_DONE;
        else if (cmd.func == FN_READ) state_next = ST_DONE;
        else state_next = ST_MUL;
      end
      ST_MUL:   state_next = ST_PREP;
      ST_PREP:  state_next = ST_RED;
      ST_RED:   if (bitc == 7'd0) state_next = ST_FIX;
      ST_FIX:   state_next = ST_STORE;
      ST_STORE: state_next = ST_DONE;
      ST_SHRED: if (bitc == 7'd0) state_next = ST_COPY;
      ST_COPY:  if (cnt == CW'(SLOTS - 1)) state_next = ST_PERM;
      ST_PERM:  if (cnt == CW'(2*HALF - 1)) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready = (state == ST_IDLE) && !m_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (state == ST_DONE) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) vld[i] <= 1'b0;
    end else begin
      if (state == ST_STORE) vld[cmd.idx[AW-1:0]] <= 1'b1;
      if (state == ST_PERM) vld[cidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd <= q_cmd;
        cnt <= '0;
      end
      ST_LOAD: begin
        m_eff <= (mlo < VB'(2)) ? VB'(1) : mlo;
        x     <= rd_val;
        a     <= cmd.operand[VB-1:0];
        res   <= rd_val;
        // magnitude of the step, sign reapplied after reduction
        shv   <= cmd.shift[15] ? {1'b0, -cmd.shift} : {1'b0, cmd.shift};
        bitc  <= 7'd16;
        if (!cmd.in_range) res <= '0;
      end
      ST_MUL: begin
        case (cmd.func)
          FN_WRITE: prod <= {{VB{1'b0}}, a};
          FN_ADD:   prod <= {{(VB-1){1'b0}}, {1'b0, x} + {1'b0, a}};
          // x - a plus a multiple of m, never negative
          FN_SUB:   prod <= {m_eff, x} - {{VB{1'b0}}, a};
          FN_MUL:   prod <= x * a;
          default:  prod <= {{VB{1'b0}}, x};
        endcase
        bitc <= 7'(2*VB);
        rem  <= '0;
      end
      ST_PREP: ;
      ST_RED: begin
        // restoring reduction, one product bit per cycle
        if (bitc != 7'd0) begin
          logic [VB+1:0] t;
          t = {rem, prod[2*VB-1]};
          if (t >= {2'b0, m_eff}) t = t - {2'b0, m_eff};
          rem  <= t[VB:0];
          prod <= {prod[2*VB-2:0], 1'b0};
          bitc <= bitc - 7'd1;
        end
      end
      ST_FIX: begin
        case (cmd.func)
          FN_NEG: res <= (rem == '0) ? '0 : VB'(m_eff - VB'(rem));
          default: res <= VB'(rem);
        endcase
      end
      ST_STORE: ;
      ST_SHRED: begin
        if (bitc != 7'd0) begin
          // take off half-row multiples, one power of two per cycle
          if ({15'd0, shv} >= (32'(HALF) << (bitc - 7'd1)))
            shv <= shv - 17'(32'(HALF) << (bitc - 7'd1));
          bitc <= bitc - 7'd1;
        end else begin
          if (cmd.shift[15] && shv != '0) r_sh <= HW'(HALF) - HW'(shv);
          else r_sh <= HW'(shv);
        end
      end
      ST_COPY: begin
        if (cmd.func == FN_SWAP) r_sh <= '0;
        if (cnt == CW'(SLOTS - 1)) cnt <= '0;
        else cnt <= cnt + CW'(1);
      end
      ST_PERM: cnt <= cnt + CW'(1);
      ST_DONE: begin
        slot_result <= (cmd.func == FN_SWAP || cmd.func == FN_ROTATE) ? '0
                       : {{(DATA_BITS-VB){1'b0}}, res};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_STORE) store[cmd.idx[AW-1:0]] <= res;
    if (state == ST_COPY) copy[cidx] <= vld[cidx] ? store[cidx] : '0;
    if (state == ST_PERM) store[cidx] <= cp_val;
  end

  `include "slot_vector_mod_alu_assert.svh"
  `SVMA_ASSERT(a_hold_result, clk, rst, (m_valid && !m_ready) |=> m_valid)
  `SVMA_ASSERT(a_no_take_busy, clk, rst, (state != ST_IDLE) |-> !q_ready)
  `SVMA_ASSERT(a_done_sets, clk, rst, (state == ST_DONE) |=> m_valid)
endmodule
`default_nettype wire

// ===== hw/rtl/slot_vector_mod_alu.sv =====
// slot vector modular alu: one item at a time, result held in an output register
// arithmetic items go through a bit-serial 64-bit reduction
// column swap copies and permutes the slots, row rotation does the same after a
// 16-step shift reduction
// reset: slots read as zero via valid bits, modulus returns to 65537
`timescale 1ns / 1ps
`default_nettype none
module slot_vector_mod_alu #(
  parameter int SLOTS      = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire [31:0]  cfg_wdata,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [63:0]  s_axis_tdata,  // slot_index[11:0], operand_value[43:12], shift[59:44]
  input  wire [2:0]   s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata   // slot_result
);
  import svma_pkg::*;

  logic [31:0] modulus;
  logic        q_valid, q_ready;
  cmd_t        q_cmd;

  always_ff @(posedge clk) begin
    if (rst) modulus <= 32'd65537;
    else if (cfg_we) modulus <= cfg_wdata;
  end

  svma_front #(.SLOTS(SLOTS)) u_front (
    .clk, .rst,
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
    .func(s_axis_tuser), .slot_index(s_axis_tdata[11:0]),
    .operand_value(s_axis_tdata[43:12]), .shift_amount(s_axis_tdata[59:44]),
    .q_valid, .q_ready, .q_cmd
  );

  svma_back #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .modulus,
    .q_valid, .q_ready, .q_cmd,
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .slot_result(m_axis_tdata)
  );
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// testbench for slot_vector_mod_alu: random and directed slot operations under stream handshakes
// depends on svma_pkg and the slot_vector_mod_alu rtl
`timescale 1ns / 1ps
module tb;
  import svma_pkg::*;

  localparam int NSLOT = 16;
  localparam int HALF = NSLOT / 2;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    func_t       func;
    logic [11:0] idx;
    logic [31:0] opnd;
    logic [15:0] shift;
  } op_item_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;

  slot_vector_mod_alu uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  op_item_t pending_ops[$];
  logic [31:0] slot_results_due[$];
  logic [31:0] slots[NSLOT];
  logic [31:0] cur_mod;
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit hold_send = 0;
  bit cur_valid = 0;
  bit in_taken = 0;
  int rx_phase = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // advance the slot vector for one accepted transfer
  function automatic logic [31:0] apply_op(input op_item_t it);
    logic [63:0] m, x, a;
    logic [31:0] tmp[NSLOT];
    int sv, r;
    m = (cur_mod < 2) ? 64'd1 : {32'd0, cur_mod};
    a = {32'd0, it.opnd};
    if (it.func == FN_SWAP) begin
      for (int i = 0; i < HALF; i++) begin
        tmp[0] = slots[i]; slots[i] = slots[i + HALF]; slots[i + HALF] = tmp[0];
      end
      return 0;
    end
    if (it.func == FN_ROTATE) begin
      sv = $signed(it.shift);
      r = sv % HALF;
      if (r < 0) r += HALF;
      tmp = slots;
      for (int i = 0; i < HALF; i++) begin
        slots[i] = tmp[(i + r) % HALF];
        slots[i + HALF] = tmp[HALF + (i + r) % HALF];
      end
      return 0;
    end
    if (it.idx >= NSLOT) return 0;
    x = {32'd0, slots[it.idx]};
    case (it.func)
      FN_WRITE: x = a % m;
      FN_ADD:   x = (x + a) % m;
      FN_SUB:   x = (x + (m - (a % m))) % m;
      FN_MUL:   x = (x * a) % m;
      FN_NEG:   x = (m - (x % m)) % m;
      default: ;
    endcase
    slots[it.idx] = x[31:0];
    return x[31:0];
  endfunction

  function automatic op_item_t mk(input func_t f, input logic [11:0] i,
                                  input logic [31:0] a, input logic [15:0] s);
    op_item_t it;
    it.func = f; it.idx = i; it.opnd = a; it.shift = s;
    return it;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return $urandom_range(0, 3);
      2: return cur_mod - $urandom_range(0, 2);
      default: return $urandom;
    endcase
  endfunction

  function automatic op_item_t rand_op();
    logic [11:0] i;
    logic [15:0] s;
    i = ($urandom_range(0, 15) == 0) ? 12'($urandom) : 12'($urandom_range(0, NSLOT - 1));
    s = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 40)) - 20);
    return mk(func_t'($urandom_range(0, 7)), i, rand_val(), s);
  endfunction

  // driver: bursts and gaps, one transfer per handshake
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) cur_valid = 0;
      if (!cur_valid && !hold_send && pending_ops.size() > 0) begin
        if (burst_left > 0) begin
          op_item_t it;
          it = pending_ops.pop_front();
          s_axis_tdata <= {4'd0, it.shift, it.opnd, it.idx};
          s_axis_tuser <= it.func;
          slot_results_due.push_back(apply_op(it));
          cur_valid = 1;
          burst_left--;
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        end
      end
      s_axis_tvalid <= cur_valid;
      rx_phase++;
      m_axis_tready <= (rx_phase % 97 < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    in_taken = s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (slot_results_due.size() == 0) report("result with nothing expected");
        else begin
          logic [31:0] want;
          want = slot_results_due.pop_front();
          if (m_axis_tdata !== want)
            report($sformatf("slot_result got %h want %h", m_axis_tdata, want));
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("FAIL slot_vector_mod_alu");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_ops.size() > 0 || cur_valid || s_axis_tvalid) @(posedge clk);
    while (slot_results_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_mod(input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    cur_mod = v;
  endtask

  initial begin
    logic [31:0] mods[7];
    mods = '{32'd65537, 32'hFFFF_FFFF, 32'd2, 32'd0, 32'd1, 32'd97, 32'h8000_0001};
    cur_mod = 32'd65537;
    foreach (slots[i]) slots[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 0;
    // directed: extremes, all functions, out of range index, rotations
    pending_ops.push_back(mk(FN_READ, 3, 0, 0));
    pending_ops.push_back(mk(FN_WRITE, 0, 32'hFFFF_FFFF, 0));
    pending_ops.push_back(mk(FN_WRITE, 15, 32'd65536, 0));
    pending_ops.push_back(mk(FN_ADD, 15, 32'hFFFF_FFFF, 0));
    pending_ops.push_back(mk(FN_SUB, 0, 32'hFFFF_FFFF, 0));
    pending_ops.push_back(mk(FN_MUL, 15, 32'hFFFF_FFFF, 0));
    pending_ops.push_back(mk(FN_NEG, 0, 0, 0));
    pending_ops.push_back(mk(FN_NEG, 1, 0, 0));
    pending_ops.push_back(mk(FN_WRITE, 12'hFFF, 5, 0));
    pending_ops.push_back(mk(FN_READ, 16, 0, 0));
    pending_ops.push_back(mk(FN_SWAP, 0, 0, 0));
    pending_ops.push_back(mk(FN_ROTATE, 0, 0, 16'sd3));
    pending_ops.push_back(mk(FN_ROTATE, 0, 0, 16'h8000));
    pending_ops.push_back(mk(FN_ROTATE, 0, 0, 16'h7FFF));
    pending_ops.push_back(mk(FN_ROTATE, 0, 0, 16'hFFFF));
    for (int i = 0; i < NSLOT; i++) pending_ops.push_back(mk(FN_READ, i, 0, 0));
    drain();
    for (int p = 0; p < 7; p++) begin
      set_mod(mods[p]);
      for (int n = 0; n < 120; n++) pending_ops.push_back(rand_op());
      // let part of the batch go, then hold off until everything outstanding has come back
      while (pending_ops.size() > 60) @(posedge clk);
      hold_send = 1;
      while (slot_results_due.size() > 0 || cur_valid) @(posedge clk);
      hold_send = 0;
      for (int n = 0; n < 120; n++) pending_ops.push_back(rand_op());
      drain();
      set_mod($urandom | 32'd2);
      for (int n = 0; n < 5; n++) pending_ops.push_back(mk(FN_READ, $urandom_range(0, 15), 0, 0));
      drain();
    end
    if (errors == 0) $display("PASS slot_vector_mod_alu");
    else $display("FAIL slot_vector_mod_alu");
    $finish;
  end
endmodule
